// ===== sv/ctf_pkg.sv =====
// Shared widths, constants and the CORDIC arctangent table of the complementary tilt filter.
`default_nettype none

package ctf_pkg;

    localparam int DATA_W     = 16;
    localparam int IN_DATA_W  = 4 * DATA_W;
    localparam int CFG_IDX_W  = 1;
    localparam int XY_W       = 27;
    localparam int Z_W        = 21;
    localparam int GT_W       = 21;
    localparam int MUL_A_W    = 17;
    localparam int MUL_P_W    = MUL_A_W + GT_W;
    localparam int ACC_W      = MUL_P_W;
    localparam int TABLE_LEN  = 20;
    localparam int ITER_W     = 5;
    localparam int CORDIC_STEPS_DEFAULT = 14;

    localparam logic signed [Z_W-1:0] PI_Q16 = Z_W'(205887);

    localparam logic [DATA_W-1:0] GYRO_WEIGHT_RESET  = 16'd32113;
    localparam logic [DATA_W-1:0] ACCEL_WEIGHT_RESET = 16'd655;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WEIGHT = 1'd1;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(51472);
            5'd1:    v = Z_W'(30385);
            5'd2:    v = Z_W'(16055);
            5'd3:    v = Z_W'(8150);
            5'd4:    v = Z_W'(4091);
            5'd5:    v = Z_W'(2047);
            5'd6:    v = Z_W'(1024);
            5'd7:    v = Z_W'(512);
            5'd8:    v = Z_W'(256);
            5'd9:    v = Z_W'(128);
            5'd10:   v = Z_W'(64);
            5'd11:   v = Z_W'(32);
            5'd12:   v = Z_W'(16);
            5'd13:   v = Z_W'(8);
            5'd14:   v = Z_W'(4);
            5'd15:   v = Z_W'(2);
            5'd16:   v = Z_W'(1);
            5'd17:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/complementary_tilt_filter_core.sv =====
// Complementary tilt filter: CORDIC atan2 of two accelerometer axes blended with gyro integration.
//
// Channel   Dir  Handshake                    Contents
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: accel_first, accel_second, gyro_rate,
//                                             elapsed_time; tuser: restart
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: tilt_angle
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data (0 gyro_weight, 1 accel_weight)
//
// An item is taken only in S_IDLE, once the previous one is finished. It then passes S_PREP,
// the CORDIC loop of min(CORDIC_STEPS, 20) steps, one micro-rotation per cycle, then S_FINAL,
// S_MULG, S_MULA and S_DONE; S_PREP, S_MULG and S_MULA use the shared 17 x 21 bit multiplier
// for the gyro step and the two blend products.
// rst_n clears the estimate to zero and loads the default weights.
// The result register holds a finished tilt while the next item is already being worked on;
// a stalled output only holds the block at the end of the following item.
`default_nettype none

module complementary_tilt_filter_core
    import ctf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // accel_first [15:0], accel_second [31:16], gyro_rate [47:32], elapsed_time [63:48]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // restart [0]
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tilt_angle [15:0]
    output logic [DATA_W-1:0]          m_axis_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0]     cfg_data
);

    localparam int STEPS_EFF = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(STEPS_EFF - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ITER,
        S_FINAL,
        S_MULG,
        S_MULA,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [ITER_W-1:0]           iter_reg;
    logic signed [DATA_W-1:0]    accel_first_reg;
    logic signed [DATA_W-1:0]    accel_second_reg;
    logic signed [DATA_W-1:0]    gyro_rate_reg;
    logic [DATA_W-1:0]           elapsed_time_reg;
    logic                        restart_reg;
    logic                        zero_vec_reg;
    logic signed [XY_W-1:0]      x_reg;
    logic signed [XY_W-1:0]      y_reg;
    logic signed [Z_W-1:0]       z_reg;
    logic signed [DATA_W-1:0]    accel_tilt_reg;
    logic signed [GT_W-1:0]      gyro_angle_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [DATA_W-1:0]    prev_tilt_reg;
    logic [DATA_W-1:0]           gyro_weight_reg;
    logic [DATA_W-1:0]           accel_weight_reg;
    logic                        m_tvalid_reg;
    logic [DATA_W-1:0]           m_tdata_reg;

    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [GT_W-1:0]      mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic signed [XY_W-1:0]      x_shift;
    logic signed [XY_W-1:0]      y_shift;
    logic signed [XY_W-1:0]      x_init;
    logic signed [XY_W-1:0]      y_init;
    logic signed [Z_W:0]         z_round;
    logic signed [Z_W-3:0]       z_scaled;
    logic signed [ACC_W-1:0]     step_full;
    logic signed [ACC_W-16:0]    blend_full;
    logic signed [DATA_W-1:0]    blend_sat;
    logic signed [DATA_W-1:0]    result;
    logic                        out_free;

    function automatic logic signed [DATA_W-1:0] sat_z(input logic signed [Z_W-3:0] v);
        if (v > (Z_W-2)'(32767)) begin
            return 16'sh7FFF;
        end
        if (v < -(Z_W-2)'(32768)) begin
            return 16'sh8000;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_blend(input logic signed [ACC_W-16:0] v);
        if (v > (ACC_W-15)'(32767)) begin
            return 16'sh7FFF;
        end
        if (v < -(ACC_W-15)'(32768)) begin
            return 16'sh8000;
        end
        return v[DATA_W-1:0];
    endfunction

    always_comb
    begin
        case (state_reg)
            S_PREP:
            begin
                mul_a = {gyro_rate_reg[DATA_W-1], gyro_rate_reg};
                mul_b = $signed({{(GT_W-DATA_W){1'b0}}, elapsed_time_reg});
            end
            S_MULG:
            begin
                mul_a = $signed({1'b0, gyro_weight_reg});
                mul_b = gyro_angle_reg;
            end
            S_MULA:
            begin
                mul_a = $signed({1'b0, accel_weight_reg});
                mul_b = GT_W'(accel_tilt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign x_shift = x_reg >>> iter_reg;
    assign y_shift = y_reg >>> iter_reg;
    assign x_init = $signed({{(XY_W-DATA_W-8){accel_second_reg[DATA_W-1]}},
                             accel_second_reg, 8'b0});
    assign y_init = $signed({{(XY_W-DATA_W-8){accel_first_reg[DATA_W-1]}},
                             accel_first_reg, 8'b0});

    assign z_round = (Z_W+1)'(z_reg) + (Z_W+1)'(4);
    assign z_scaled = z_round[Z_W:3];

    assign step_full = acc_reg >>> 13;
    assign blend_full = acc_reg[ACC_W-1:15];
    assign blend_sat = sat_blend(blend_full);
    assign result = restart_reg ? accel_tilt_reg : blend_sat;
    assign out_free = !m_tvalid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            iter_reg         <= '0;
            accel_first_reg  <= '0;
            accel_second_reg <= '0;
            gyro_rate_reg    <= '0;
            elapsed_time_reg <= '0;
            restart_reg      <= 1'b0;
            zero_vec_reg     <= 1'b0;
            x_reg            <= '0;
            y_reg            <= '0;
            z_reg            <= '0;
            accel_tilt_reg   <= '0;
            gyro_angle_reg   <= '0;
            acc_reg          <= '0;
            prev_tilt_reg    <= '0;
            gyro_weight_reg  <= GYRO_WEIGHT_RESET;
            accel_weight_reg <= ACCEL_WEIGHT_RESET;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GYRO_WEIGHT:  gyro_weight_reg  <= cfg_data;
                    REG_ACCEL_WEIGHT: accel_weight_reg <= cfg_data;
                    default:          ;
                endcase
            end

            if (m_tvalid_reg && m_axis_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid) begin
                        accel_first_reg  <= s_axis_tdata[DATA_W-1:0];
                        accel_second_reg <= s_axis_tdata[2*DATA_W-1:DATA_W];
                        gyro_rate_reg    <= s_axis_tdata[3*DATA_W-1:2*DATA_W];
                        elapsed_time_reg <= s_axis_tdata[4*DATA_W-1:3*DATA_W];
                        restart_reg      <= s_axis_tuser;
                        state_reg        <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    zero_vec_reg <= (accel_first_reg == '0) && (accel_second_reg == '0);
                    if (accel_second_reg[DATA_W-1]) begin
                        x_reg <= -x_init;
                        y_reg <= -y_init;
                        z_reg <= accel_first_reg[DATA_W-1] ? -PI_Q16 : PI_Q16;
                    end else begin
                        x_reg <= x_init;
                        y_reg <= y_init;
                        z_reg <= '0;
                    end
                    acc_reg   <= mul_p + ACC_W'(4096);
                    iter_reg  <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (iter_reg == '0) begin
                        gyro_angle_reg <= GT_W'(prev_tilt_reg) + step_full[GT_W-1:0];
                    end
                    if (!y_reg[XY_W-1]) begin
                        x_reg <= x_reg + y_shift;
                        y_reg <= y_reg - x_shift;
                        z_reg <= z_reg + atan_entry(iter_reg);
                    end else begin
                        x_reg <= x_reg - y_shift;
                        y_reg <= y_reg + x_shift;
                        z_reg <= z_reg - atan_entry(iter_reg);
                    end
                    if (iter_reg == LAST_ITER) begin
                        state_reg <= S_FINAL;
                    end else begin
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                S_FINAL:
                begin
                    accel_tilt_reg <= zero_vec_reg ? '0 : sat_z(z_scaled);
                    state_reg      <= S_MULG;
                end
                S_MULG:
                begin
                    acc_reg   <= mul_p + ACC_W'(16384);
                    state_reg <= S_MULA;
                end
                S_MULA:
                begin
                    acc_reg   <= acc_reg + mul_p;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free) begin
                        m_tdata_reg   <= result;
                        m_tvalid_reg  <= 1'b1;
                        prev_tilt_reg <= result;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == S_PREP)
        else $error("accepted item did not start the sequence");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ITER |-> iter_reg <= LAST_ITER)
        else $error("CORDIC counter ran past the last step");

    a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_free && restart_reg
        |=> m_tdata_reg == $past(accel_tilt_reg))
        else $error("restart result differs from accelerometer tilt");

    a_prev_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_free |=> prev_tilt_reg == m_tdata_reg && m_tvalid_reg)
        else $error("stored estimate differs from delivered result");

endmodule

`default_nettype wire

// ===== dv/tb_complementary_tilt_filter_core.sv =====
// Self-checking testbench for the complementary tilt filter core against a tilt predictor.
module tb_complementary_tilt_filter_core;
    import ctf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROT_STEPS = (CORDIC_STEPS_DEFAULT > 20) ? 20 : CORDIC_STEPS_DEFAULT;

    typedef struct {
        logic signed [DATA_W-1:0] ay;
        logic signed [DATA_W-1:0] ax;
        logic signed [DATA_W-1:0] rate;
        logic [DATA_W-1:0]        dt;
        logic                     restart;
    } sensor_sample_t;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    val;
    } weight_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0]     cfg_data = '0;

    sensor_sample_t           sample_q[$];
    weight_write_t            weight_q[$];
    logic signed [DATA_W-1:0] tilt_due[$];

    logic [DATA_W-1:0]        gyro_w = GYRO_WEIGHT_RESET;
    logic [DATA_W-1:0]        accel_w = ACCEL_WEIGHT_RESET;
    logic signed [DATA_W-1:0] est_tilt = '0;
    logic                     steady = 1'b0;

    int err_count = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int weight_writes = 0;

    complementary_tilt_filter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint rot_angle(input int n);
        case (n)
            0:       return 51472;
            1:       return 30385;
            2:       return 16055;
            3:       return 8150;
            4:       return 4091;
            5:       return 2047;
            6:       return 1024;
            7:       return 512;
            8:       return 256;
            9:       return 128;
            10:      return 64;
            11:      return 32;
            12:      return 16;
            13:      return 8;
            14:      return 4;
            15:      return 2;
            16:      return 1;
            17:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Vectoring CORDIC; the angle accumulates in 2^-16 rad and is rounded to 2^-13 rad.
    function automatic longint accel_angle(input longint y, input longint x);
        longint z;
        longint xs;
        longint ys;
        int     n;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0)
        begin
            z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
            x = -x;
            y = -y;
        end
        for (n = 0; n < ROT_STEPS; n++)
        begin
            xs = x >>> n;
            ys = y >>> n;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + rot_angle(n);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - rot_angle(n);
            end
        end
        return (z + 4) >>> 3;
    endfunction

    function automatic logic signed [DATA_W-1:0] fuse_tilt(
        input logic signed [DATA_W-1:0] ay,
        input logic signed [DATA_W-1:0] ax,
        input logic signed [DATA_W-1:0] rate,
        input logic [DATA_W-1:0]        dt,
        input logic                     restart
    );
        longint acc_tilt;
        longint step;
        longint gyro_angle;
        longint blend;
        acc_tilt = clamp16(accel_angle(longint'(ay), longint'(ax)));
        if (restart)
            blend = acc_tilt;
        else
        begin
            step = (longint'(rate) * longint'(dt) + 4096) >>> 13;
            gyro_angle = longint'(est_tilt) + step;
            blend = clamp16((longint'(gyro_w) * gyro_angle + longint'(accel_w) * acc_tilt
                             + 16384) >>> 15);
        end
        est_tilt = blend[DATA_W-1:0];
        return est_tilt;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR: %s", $time, what);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        sensor_sample_t s;
        weight_write_t  w;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                tilt_due.push_back(fuse_tilt(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                             s_axis_tdata[47:32], s_axis_tdata[63:48],
                                             s_axis_tuser));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (sample_q.size() != 0 && (steady || $urandom_range(99) >= 15))
                begin
                    s = sample_q.pop_front();
                    s_axis_tdata <= {s.dt, s.rate, s.ax, s.ay};
                    s_axis_tuser <= s.restart;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GYRO_WEIGHT)
                    gyro_w = cfg_data;
                else if (cfg_index == REG_ACCEL_WEIGHT)
                    accel_w = cfg_data;
                weight_writes++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (weight_q.size() != 0 && (steady || $urandom_range(99) >= 15))
                begin
                    w = weight_q.pop_front();
                    cfg_index <= w.idx;
                    cfg_data <= w.val;
                    cfg_valid <= 1'b1;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : watch
        logic signed [DATA_W-1:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (tilt_due.size() == 0)
                    report_mismatch($sformatf("tilt %0d arrived with no sample pending",
                                              $signed(m_axis_tdata)));
                else
                begin
                    want = tilt_due.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch($sformatf("tilt_angle %0d, predicted %0d",
                                                  $signed(m_axis_tdata), want));
                    results_seen++;
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 15);
        end
    end

    task automatic settle;
        while (sample_q.size() != 0 || s_axis_tvalid || tilt_due.size() != 0
               || weight_q.size() != 0 || cfg_valid)
            @(negedge clk);
    endtask

    task automatic add_sample(input logic signed [DATA_W-1:0] ay,
                              input logic signed [DATA_W-1:0] ax,
                              input logic signed [DATA_W-1:0] rate, input logic [DATA_W-1:0] dt,
                              input logic restart);
        sensor_sample_t s;
        s.ay = ay;
        s.ax = ax;
        s.rate = rate;
        s.dt = dt;
        s.restart = restart;
        sample_q.push_back(s);
    endtask

    function automatic logic signed [DATA_W-1:0] corner_value;
        case ($urandom_range(4))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return -16'sd1;
        endcase
    endfunction

    task automatic add_random_sample;
        logic signed [DATA_W-1:0] ay;
        logic signed [DATA_W-1:0] ax;
        logic signed [DATA_W-1:0] rate;
        logic [DATA_W-1:0]        dt;
        case ($urandom_range(3))
            0:
            begin
                ay = 16'($urandom);
                ax = 16'($urandom);
            end
            1:
            begin
                ay = 16'($urandom_range(600) - 300);
                ax = 16'($urandom_range(600) - 300);
            end
            2:
            begin
                ay = corner_value();
                ax = corner_value();
            end
            default:
            begin
                ay = 16'($urandom);
                ax = 16'($urandom);
                if ($urandom_range(1))
                    ay = '0;
                else
                    ax = '0;
            end
        endcase
        rate = ($urandom_range(3) == 0) ? 16'($urandom_range(2000) - 1000) : 16'($urandom);
        dt = $urandom_range(1) ? 16'($urandom_range(2000)) : 16'($urandom);
        add_sample(ay, ax, rate, dt, $urandom_range(11) == 0);
    endtask

    task automatic run_phase(input logic [DATA_W-1:0] gw, input logic [DATA_W-1:0] aw,
                             input int count, input logic no_gap, input logic pause);
        weight_write_t w;
        int            i;
        w.idx = REG_GYRO_WEIGHT;
        w.val = gw;
        weight_q.push_back(w);
        w.idx = REG_ACCEL_WEIGHT;
        w.val = aw;
        weight_q.push_back(w);
        settle();
        steady = no_gap;
        for (i = 0; i < count; i++)
        begin
            // Hold the stream until every tilt in flight has come back.
            if (pause && i == count / 2)
                settle();
            add_random_sample();
        end
        settle();
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_sample(16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1);
        add_sample(16'sd0, 16'sd0, 16'sd100, 16'd1000, 1'b0);
        add_sample(16'sd0, -16'sd100, 16'sd0, 16'd0, 1'b1);
        add_sample(-16'sd1, 16'sh8000, 16'sd0, 16'd0, 1'b1);
        add_sample(16'sd0, -16'sd1, 16'sd0, 16'd0, 1'b0);
        add_sample(16'sh7FFF, 16'sd0, 16'sd0, 16'd0, 1'b1);
        add_sample(16'sh8000, 16'sd0, 16'sd0, 16'd0, 1'b1);
        add_sample(16'sd0, 16'sh7FFF, 16'sd0, 16'd0, 1'b0);
        add_sample(16'sh8000, 16'sh8000, 16'sd0, 16'd0, 1'b1);
        add_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b0);
        add_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0);
        add_sample(16'sd1, 16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0);
        add_sample(16'sh8000, 16'sd1, 16'sh8000, 16'hFFFF, 1'b0);
        add_sample(16'sh7FFF, 16'sh8000, -16'sd1, 16'hFFFF, 1'b0);
        add_sample(16'sd1, 16'sd1, 16'sd1, 16'd1, 1'b0);
        add_sample(-16'sd1, -16'sd1, -16'sd1, 16'd0, 1'b0);
        add_sample(16'sd100, 16'sd0, 16'sh7FFF, 16'hFFFF, 1'b0);
        add_sample(16'sd100, 16'sd0, 16'sh7FFF, 16'hFFFF, 1'b0);
        add_sample(-16'sd100, 16'sd0, 16'sh8000, 16'hFFFF, 1'b0);
        add_sample(-16'sd100, 16'sd0, 16'sh8000, 16'hFFFF, 1'b0);
        add_sample(16'sd12345, -16'sd23456, -16'sd12345, 16'd4096, 1'b1);
        settle();

        run_phase(16'd32768, 16'd0, 80, 1'b0, 1'b0);
        run_phase(16'd0, 16'd32768, 80, 1'b0, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 80, 1'b0, 1'b0);
        run_phase(16'd16384, 16'd16384, 100, 1'b1, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 60, 1'b0, 1'b0);
        run_phase(16'd0, 16'd0, 40, 1'b0, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 60, 1'b0, 1'b1);
        run_phase(GYRO_WEIGHT_RESET, ACCEL_WEIGHT_RESET, 100, 1'b0, 1'b0);

        repeat (40) @(negedge clk);
        if (tilt_due.size() != 0)
            report_mismatch($sformatf("%0d predicted tilts never arrived", tilt_due.size()));

        $display("Covered %0d samples and %0d tilt results under %0d weight register writes,",
                 samples_sent, results_seen, weight_writes);
        $display("including restarts, zero and negative axes, extreme rates and saturation.");
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== complementary_tilt_filter_core.f =====
sv/ctf_pkg.sv
sv/complementary_tilt_filter_core.sv
dv/tb_complementary_tilt_filter_core.sv
